>>> rtl/scba_pkg.sv
// Shared types, constants and helpers of the size class block allocator.
`timescale 1ns / 1ps

package scba_pkg;

    // Field widths
    localparam int FUNC_W     = 1;
    localparam int SIZE_W     = 25;
    localparam int ADDR_IN_W  = 32;
    localparam int STATUS_W   = 2;
    localparam int CLS_OUT_W  = 4;
    localparam int USED_W     = 16;
    localparam int FREE_OUT_W = 7;
    localparam int LP_W       = 16;          // large page count, compared in 16 bits
    localparam int PG_W       = SIZE_W + 1;  // page count before truncation
    localparam int PL_W       = 5;           // page_log register
    localparam int PL_MAX     = (2 ** PL_W) - 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Parameter defaults
    localparam int NUM_CLASSES_DEF = 16;
    localparam int STACK_DEPTH_DEF = 64;
    localparam int LARGE_DEPTH_DEF = 16;
    localparam int ADDR_WIDTH_DEF  = 32;

    // Register reset values
    localparam logic [PL_W-1:0]       PAGE_LOG_RST = PL_W'(12);
    localparam logic [CFG_DATA_W-1:0] LIMIT_RST    = '1;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LOG     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_BASE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REGION_LIMIT = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FRESH    = 2'd1,
        STAT_NO_SPACE = 2'd2,
        STAT_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [SIZE_W-1:0]    request_size;
        logic [ADDR_IN_W-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_IN_W-1:0]  result_address;
        t_status               status;
        logic [CLS_OUT_W-1:0]  size_class;
        logic [USED_W-1:0]     used_count;
        logic [FREE_OUT_W-1:0] free_count;
    } t_rsp;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SIZE,
        ST_COUNT,
        ST_STK,
        ST_LRD,
        ST_LCMP,
        ST_LMV_RD,
        ST_LMV_WR,
        ST_FRESH1,
        ST_FRESH2,
        ST_FRESH3,
        ST_CWR,
        ST_DONE
    } t_state;

    function automatic logic [USED_W-1:0] used_inc(input logic [USED_W-1:0] v);
        used_inc = (v == '1) ? v : v + USED_W'(1);
    endfunction

    function automatic logic [USED_W-1:0] used_dec(input logic [USED_W-1:0] v);
        used_dec = (v == '0) ? v : v - USED_W'(1);
    endfunction

endpackage

>>> rtl/scba_cnt_mem.sv
// Per-class counter table: one-port synchronous memory with valid bits.
`timescale 1ns / 1ps

module scba_cnt_mem import scba_pkg::*; #(
    parameter int DEPTH = NUM_CLASSES_DEF,
    parameter int WIDTH = USED_W + 7
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_re,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rdata;
    logic             r_rd_valid;

    // valid bits: an entry never written reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_we) begin
                r_valid[i_addr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_valid <= r_valid[i_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rd_valid ? r_rdata : '0;

endmodule

>>> rtl/scba_blk_mem.sv
// Block address memory: free stacks followed by the large block list.
`timescale 1ns / 1ps

module scba_blk_mem import scba_pkg::*; #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = ADDR_WIDTH_DEF + LP_W
) (
    input  logic                     i_clk,
    input  logic                     i_re,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/size_class_block_allocator_core.sv
// Top level of the size class block allocator: request sequencer and datapath.
`timescale 1ns / 1ps
//   Request channel (i_req_valid / o_req_ready / i_req): one allocate or free
//   request per handshake. The size is rounded up to pages of 2**page_log
//   bytes. Small blocks (1..NUM_CLASSES-2 pages) use per-class LIFO stacks,
//   larger ones a single list searched newest first for a 16-bit page count match.
//   Allocations that find nothing take fresh space from the bump pointer,
//   skipping one guard page.
//   Response channel (o_rsp_valid / i_rsp_ready / o_rsp): exactly one response
//   per request, in order.
//   Config channel (i_cfg_valid / o_cfg_ready, always ready): page_log,
//   region_base (also loads the bump pointer), region_limit. Write when idle.
// Sequencing
//   One request at a time. A large allocate searches the list entry by entry,
//   closes the gap on a match, and falls back to fresh space on a miss. Ready
//   returns in the cycle after the response loads.
// Reset: synchronous, active low. Counters read as zero via valid bits, the
//   list is emptied, bump pointer 0; no clearing pass is needed.
// Stall: the response sits in an output register; the next request is taken
//   while it waits, and the sequencer holds its result until the slot frees.

module size_class_block_allocator_core import scba_pkg::*; #(
    parameter int NUM_CLASSES = NUM_CLASSES_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int LARGE_DEPTH = LARGE_DEPTH_DEF,
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  t_req                  i_req,
    output logic                  o_rsp_valid,
    input  logic                  i_rsp_ready,
    output t_rsp                  o_rsp,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int CLS_W      = $clog2(NUM_CLASSES);
    localparam int SD_W       = $clog2(STACK_DEPTH);
    localparam int FC_W       = $clog2(STACK_DEPTH + 1);
    localparam int LE_W       = $clog2(LARGE_DEPTH + 1);
    localparam int LI_W       = $clog2(LARGE_DEPTH);
    localparam int FCW        = (FC_W > LE_W) ? FC_W : LE_W;
    localparam int BP_W       = (ADDR_WIDTH + 1 > CFG_DATA_W) ? ADDR_WIDTH + 1 : CFG_DATA_W;
    localparam int SUM_W      = ((BP_W > PG_W + PL_MAX) ? BP_W : PG_W + PL_MAX) + 1;
    localparam int STK_WORDS  = NUM_CLASSES * (2 ** SD_W);
    localparam int BM_DEPTH   = STK_WORDS + LARGE_DEPTH;
    localparam int BM_AW      = $clog2(BM_DEPTH);
    localparam int BW         = ADDR_WIDTH + LP_W;
    localparam int CW         = USED_W + FC_W;

    localparam logic [SUM_W-1:0] ADDR_MAX   = SUM_W'({ADDR_WIDTH{1'b1}});
    localparam logic [BM_AW-1:0] LARGE_BASE = BM_AW'(STK_WORDS);

    // control state
    t_state                r_state, n_state;
    logic                  r_rsp_valid;
    logic [LE_W-1:0]       r_large_entries;
    logic [BP_W-1:0]       r_bump;
    logic [PL_W-1:0]       r_page_log;
    logic [CFG_DATA_W-1:0] r_region_limit;

    // payload
    t_req                  r_req;
    t_rsp                  r_rsp;
    logic [PG_W-1:0]       r_pages;
    logic                  r_small;
    logic [CLS_W-1:0]      r_cls;
    logic [LP_W-1:0]       r_lp;
    logic [SUM_W-1:0]      r_guard;
    logic [SUM_W-1:0]      r_bytes_m1;
    logic [SUM_W-1:0]      r_fresh;
    logic [SUM_W-1:0]      r_end_m1;
    logic [USED_W-1:0]     r_used;
    logic [FCW-1:0]        r_free;
    logic [LI_W-1:0]       r_idx;
    logic [ADDR_WIDTH-1:0] r_res;
    t_status               r_status;

    // memory ports
    logic                  cnt_re, cnt_we;
    logic [CW-1:0]         cnt_wdata, cnt_rdata;
    logic                  blk_re, blk_we;
    logic [BM_AW-1:0]      blk_addr;
    logic [BW-1:0]         blk_wdata, blk_rdata;

    // decode / decision terms
    logic                  w_req_acc;
    logic                  w_cfg_we;
    logic                  w_rsp_load;
    logic                  w_alloc;
    logic [SIZE_W-1:0]     w_sm1;
    logic [PG_W-1:0]       w_pages;
    logic [USED_W-1:0]     w_cnt_used;
    logic [FC_W-1:0]       w_cnt_free;
    logic                  w_have_free;
    logic                  w_stack_full;
    logic                  w_list_full;
    logic                  w_match;
    logic                  w_more;
    logic                  w_fit;
    logic [ADDR_WIDTH-1:0] w_baddr;
    logic [SD_W-1:0]       w_slot_rd, w_slot_wr;

    assign w_req_acc   = i_req_valid && o_req_ready;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;
    assign w_rsp_load  = (r_state == ST_DONE) && (!r_rsp_valid || i_rsp_ready);
    assign w_alloc     = (r_req.func == FUNC_ALLOC);
    assign w_sm1       = (r_req.request_size != '0) ? r_req.request_size - SIZE_W'(1) : '0;
    assign w_pages     = PG_W'(w_sm1 >> r_page_log) + PG_W'(1);
    assign w_cnt_used  = cnt_rdata[FC_W +: USED_W];
    assign w_cnt_free  = cnt_rdata[FC_W-1:0];
    assign w_have_free = (w_cnt_free != '0);
    assign w_stack_full = (w_cnt_free >= FC_W'(STACK_DEPTH));
    assign w_list_full = (r_large_entries >= LE_W'(LARGE_DEPTH));
    assign w_match     = (blk_rdata[BW-1 -: LP_W] == r_lp);
    assign w_more      = (LE_W'(r_idx) + LE_W'(1)) < r_large_entries;
    assign w_fit       = !(r_end_m1 > SUM_W'(r_region_limit)) && !(r_end_m1 > ADDR_MAX);
    assign w_baddr     = ADDR_WIDTH'(r_req.block_address);
    assign w_slot_rd   = SD_W'(w_cnt_free - FC_W'(1));
    assign w_slot_wr   = SD_W'(w_cnt_free);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_DECODE;
            end
            ST_DECODE: n_state = ST_SIZE;
            ST_SIZE:   n_state = ST_COUNT;
            ST_COUNT: begin
                if (w_alloc) begin
                    if (r_small) begin
                        n_state = w_have_free ? ST_STK : ST_FRESH1;
                    end else begin
                        n_state = (r_large_entries != '0) ? ST_LRD : ST_FRESH1;
                    end
                end else begin
                    if (r_small) begin
                        n_state = w_stack_full ? ST_DONE : ST_CWR;
                    end else begin
                        n_state = w_list_full ? ST_DONE : ST_CWR;
                    end
                end
            end
            ST_STK: n_state = ST_CWR;
            ST_LRD: n_state = ST_LCMP;
            ST_LCMP: begin
                if (w_match) begin
                    n_state = ST_LMV_RD;
                end else if (r_idx == '0) begin
                    n_state = ST_FRESH1;
                end else begin
                    n_state = ST_LRD;
                end
            end
            ST_LMV_RD: n_state = w_more ? ST_LMV_WR : ST_CWR;
            ST_LMV_WR: n_state = ST_LMV_RD;
            ST_FRESH1: n_state = ST_FRESH2;
            ST_FRESH2: n_state = ST_FRESH3;
            ST_FRESH3: n_state = w_fit ? ST_CWR : ST_DONE;
            ST_CWR:    n_state = ST_DONE;
            ST_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    // ---------------- memory controls ----------------
    always_comb begin
        o_req_ready = (r_state == ST_IDLE);
        cnt_re      = (r_state == ST_SIZE);
        cnt_we      = (r_state == ST_CWR);
        cnt_wdata   = {r_used, FC_W'(r_free)};
        blk_re      = 1'b0;
        blk_we      = 1'b0;
        blk_addr    = '0;
        blk_wdata   = {LP_W'(0), w_baddr};
        case (r_state)
            ST_COUNT: begin
                if (r_small) begin
                    if (w_alloc) begin
                        // pop: top of stack
                        blk_re   = w_have_free;
                        blk_addr = BM_AW'({r_cls, w_slot_rd});
                    end else begin
                        blk_we   = !w_stack_full;
                        blk_addr = BM_AW'({r_cls, w_slot_wr});
                    end
                end else if (!w_alloc) begin
                    // append to the large list
                    blk_we    = !w_list_full;
                    blk_addr  = LARGE_BASE + BM_AW'(r_large_entries);
                    blk_wdata = {r_lp, w_baddr};
                end
            end
            ST_LRD: begin
                blk_re   = 1'b1;
                blk_addr = LARGE_BASE + BM_AW'(r_idx);
            end
            ST_LMV_RD: begin
                blk_re   = w_more;
                blk_addr = LARGE_BASE + BM_AW'(r_idx) + BM_AW'(1);
            end
            ST_LMV_WR: begin
                // close the gap: younger entry moves down one slot
                blk_we    = 1'b1;
                blk_addr  = LARGE_BASE + BM_AW'(r_idx);
                blk_wdata = blk_rdata;
            end
            default: begin
                blk_re = 1'b0;
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_rsp_valid     <= 1'b0;
            r_large_entries <= '0;
            r_bump          <= '0;
            r_page_log      <= PAGE_LOG_RST;
            r_region_limit  <= LIMIT_RST;
        end else begin
            r_state <= n_state;

            if (w_rsp_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end

            if (r_state == ST_COUNT && !w_alloc && !r_small && !w_list_full) begin
                r_large_entries <= r_large_entries + LE_W'(1);
            end else if (r_state == ST_LMV_RD && !w_more) begin
                r_large_entries <= r_large_entries - LE_W'(1);
            end

            if (w_cfg_we && i_cfg_index == CFG_REGION_BASE) begin
                r_bump <= BP_W'(i_cfg_data);
            end else if (r_state == ST_FRESH3 && w_fit) begin
                r_bump <= BP_W'(r_end_m1 + SUM_W'(1));
            end

            if (w_cfg_we && i_cfg_index == CFG_PAGE_LOG) begin
                r_page_log <= i_cfg_data[PL_W-1:0];
            end
            if (w_cfg_we && i_cfg_index == CFG_REGION_LIMIT) begin
                r_region_limit <= i_cfg_data;
            end
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_req_acc) r_req <= i_req;
            end
            ST_DECODE: begin
                r_pages <= w_pages;
                r_small <= (w_pages < PG_W'(NUM_CLASSES - 1));
                r_cls   <= (w_pages < PG_W'(NUM_CLASSES - 1)) ? w_pages[CLS_W-1:0] : '0;
                r_lp    <= w_pages[LP_W-1:0];
            end
            ST_SIZE: begin
                r_guard    <= SUM_W'(1) << r_page_log;
                r_bytes_m1 <= (SUM_W'(r_pages) << r_page_log) - SUM_W'(1);
            end
            ST_COUNT: begin
                r_res <= '0;
                if (w_alloc) begin
                    r_status <= STAT_OK;
                    r_used   <= w_cnt_used;
                    if (r_small) begin
                        r_free <= w_have_free ? FCW'(w_cnt_free - FC_W'(1))
                                              : FCW'(w_cnt_free);
                    end else begin
                        // search starts at the newest entry
                        r_free <= FCW'(r_large_entries);
                        r_idx  <= LI_W'(r_large_entries - LE_W'(1));
                    end
                end else if (r_small) begin
                    if (w_stack_full) begin
                        r_status <= STAT_FULL;
                        r_used   <= w_cnt_used;
                        r_free   <= FCW'(w_cnt_free);
                    end else begin
                        r_status <= STAT_OK;
                        r_used   <= used_dec(w_cnt_used);
                        r_free   <= FCW'(w_cnt_free) + FCW'(1);
                    end
                end else begin
                    if (w_list_full) begin
                        r_status <= STAT_FULL;
                        r_used   <= w_cnt_used;
                        r_free   <= FCW'(r_large_entries);
                    end else begin
                        r_status <= STAT_OK;
                        r_used   <= used_dec(w_cnt_used);
                        r_free   <= FCW'(r_large_entries) + FCW'(1);
                    end
                end
            end
            ST_STK: begin
                r_res  <= blk_rdata[ADDR_WIDTH-1:0];
                r_used <= used_inc(r_used);
            end
            ST_LCMP: begin
                if (w_match) begin
                    r_res <= blk_rdata[ADDR_WIDTH-1:0];
                end else if (r_idx != '0) begin
                    r_idx <= r_idx - LI_W'(1);
                end
            end
            ST_LMV_RD: begin
                if (!w_more) begin
                    r_free <= FCW'(r_large_entries - LE_W'(1));
                    r_used <= used_inc(r_used);
                end
            end
            ST_LMV_WR: begin
                r_idx <= r_idx + LI_W'(1);
            end
            ST_FRESH1: begin
                r_fresh <= SUM_W'(r_bump) + r_guard;
            end
            ST_FRESH2: begin
                r_end_m1 <= r_fresh + r_bytes_m1;
            end
            ST_FRESH3: begin
                if (w_fit) begin
                    r_res    <= ADDR_WIDTH'(r_fresh);
                    r_used   <= used_inc(r_used);
                    r_status <= STAT_FRESH;
                end else begin
                    r_res    <= '0;
                    r_status <= STAT_NO_SPACE;
                end
            end
            ST_DONE: begin
                if (w_rsp_load) begin
                    r_rsp.result_address <= ADDR_IN_W'(r_res);
                    r_rsp.status         <= r_status;
                    r_rsp.size_class     <= CLS_OUT_W'(r_cls);
                    r_rsp.used_count     <= r_used;
                    r_rsp.free_count     <= FREE_OUT_W'(r_free);
                end
            end
            default: begin
                r_res <= r_res;
            end
        endcase
    end

    scba_cnt_mem #(
        .DEPTH (NUM_CLASSES),
        .WIDTH (CW)
    ) u_cnt_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (cnt_re),
        .i_we    (cnt_we),
        .i_addr  (r_cls),
        .i_wdata (cnt_wdata),
        .o_rdata (cnt_rdata)
    );

    scba_blk_mem #(
        .DEPTH (BM_DEPTH),
        .WIDTH (BW)
    ) u_blk_mem (
        .i_clk   (i_clk),
        .i_re    (blk_re),
        .i_we    (blk_we),
        .i_addr  (blk_addr),
        .i_wdata (blk_wdata),
        .o_rdata (blk_rdata)
    );

`ifndef ASSERT_OFF
    // list never grows past its depth
    a_list_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_large_entries <= LE_W'(LARGE_DEPTH))
        else $error("large list count past depth");

    // an accepted request always starts decode next
    a_acc_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_acc |=> (r_state == ST_DECODE))
        else $error("accepted request not decoded");

    // errors carry a zero address
    a_err_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && (o_rsp.status == STAT_NO_SPACE || o_rsp.status == STAT_FULL))
        |-> (o_rsp.result_address == '0))
        else $error("error response with nonzero address");

    // gap closing only moves entries that exist
    a_move_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LMV_WR) |-> ((LE_W'(r_idx) + LE_W'(1)) < r_large_entries))
        else $error("list move past last entry");

    // bump pointer moves only on a fresh commit or a base write
    a_bump_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_bump)) |->
        ($past(r_state == ST_FRESH3) || $past(w_cfg_we && i_cfg_index == CFG_REGION_BASE)))
        else $error("bump pointer changed unexpectedly");
`endif

endmodule

>>> tb/size_class_block_allocator_core_tb.sv
// Self-checking testbench of the size class block allocator core.
`timescale 1ns / 1ps

module size_class_block_allocator_core_tb;
    import scba_pkg::*;

    localparam int SMALL_LIMIT = NUM_CLASSES_DEF - 1;  // page counts below this are small
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 130;

    // Allocator state tracker: mirrors the free stacks, the large list, the
    // counters and the bump pointer, and predicts each response from that.
    class alloc_scoreboard;
        logic [PL_W-1:0]       page_log;
        logic [CFG_DATA_W-1:0] region_base;
        logic [CFG_DATA_W-1:0] region_limit;
        logic [32:0]           bump;          // one carry bit: may point one past the limit
        logic [31:0]           stack_mem [NUM_CLASSES_DEF][STACK_DEPTH_DEF];
        int                    stack_cnt [NUM_CLASSES_DEF];
        logic [USED_W-1:0]     used_cnt [NUM_CLASSES_DEF];
        logic [31:0]           large_addr [LARGE_DEPTH_DEF];
        logic [LP_W-1:0]       large_pg [LARGE_DEPTH_DEF];
        int                    large_cnt;
        t_rsp                  awaited_rsp [$];
        t_req                  live [$];      // granted blocks, ready to be freed again
        int                    errors;
        int                    checked;
        int                    reg_writes;
        int                    status_seen [4];

        function new();
            page_log     = PAGE_LOG_RST;
            region_base  = '0;
            region_limit = LIMIT_RST;
            bump         = '0;
            large_cnt    = 0;
            errors       = 0;
            checked      = 0;
            reg_writes   = 0;
            for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
                stack_cnt[c] = 0;
                used_cnt[c]  = '0;
            end
            for (int s = 0; s < 4; s++) status_seen[s] = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            reg_writes++;
            case (idx)
                CFG_PAGE_LOG: page_log = data[PL_W-1:0];
                CFG_REGION_BASE: begin
                    region_base = data;
                    bump        = {1'b0, data};
                end
                CFG_REGION_LIMIT: region_limit = data;
                default: ;
            endcase
        endfunction

        function t_rsp predict_response(t_req r);
            logic [63:0] pages;
            logic [63:0] guard;
            logic [63:0] span;
            logic [63:0] fin;
            logic [63:0] blk;
            logic [3:0]  cls;
            logic [15:0] lp;
            logic        small_blk;
            logic        found;
            int          hit;
            t_rsp        rsp;

            rsp   = '0;
            found = 1'b0;
            hit   = -1;
            // zero bytes still costs one page
            if (r.request_size == '0) pages = 64'd1;
            else pages = ((64'(r.request_size) - 64'd1) >> page_log) + 64'd1;
            small_blk = pages < 64'(SMALL_LIMIT);
            cls = small_blk ? pages[3:0] : 4'd0;
            lp  = pages[15:0];

            if (r.func == FUNC_ALLOC) begin
                if (small_blk) begin
                    if (stack_cnt[cls] != 0) begin
                        stack_cnt[cls]--;
                        rsp.result_address = stack_mem[cls][stack_cnt[cls]];
                        found = 1'b1;
                    end
                end else begin
                    // newest entry first, exact match on the 16-bit page count
                    for (int i = large_cnt - 1; i >= 0; i--) begin
                        if (hit < 0 && large_pg[i] == lp) hit = i;
                    end
                    if (hit >= 0) begin
                        rsp.result_address = large_addr[hit];
                        for (int j = hit; j + 1 < large_cnt; j++) begin
                            large_addr[j] = large_addr[j + 1];
                            large_pg[j]   = large_pg[j + 1];
                        end
                        large_cnt--;
                        found = 1'b1;
                    end
                end
                if (found) begin
                    rsp.status = STAT_OK;
                end else begin
                    guard = 64'd1 << page_log;
                    span  = pages << page_log;
                    blk   = 64'(bump) + guard;
                    fin   = blk + span;
                    if (fin - 64'd1 > 64'(region_limit) || fin - 64'd1 > 64'hFFFF_FFFF) begin
                        rsp.status = STAT_NO_SPACE;
                    end else begin
                        rsp.status         = STAT_FRESH;
                        rsp.result_address = blk[31:0];
                        bump               = fin[32:0];
                    end
                end
                if (rsp.status != STAT_NO_SPACE) begin
                    if (used_cnt[cls] != '1) used_cnt[cls] = used_cnt[cls] + 1'b1;
                    live.push_back('{func: FUNC_FREE, request_size: r.request_size,
                                     block_address: rsp.result_address});
                end
            end else if (small_blk) begin
                if (stack_cnt[cls] >= STACK_DEPTH_DEF) begin
                    rsp.status = STAT_FULL;
                end else begin
                    stack_mem[cls][stack_cnt[cls]] = r.block_address;
                    stack_cnt[cls]++;
                    if (used_cnt[cls] != '0) used_cnt[cls] = used_cnt[cls] - 1'b1;
                end
            end else begin
                if (large_cnt >= LARGE_DEPTH_DEF) begin
                    rsp.status = STAT_FULL;
                end else begin
                    large_addr[large_cnt] = r.block_address;
                    large_pg[large_cnt]   = lp;
                    large_cnt++;
                    if (used_cnt[0] != '0) used_cnt[0] = used_cnt[0] - 1'b1;
                end
            end

            rsp.size_class = cls;
            rsp.used_count = used_cnt[cls];
            rsp.free_count = (cls == 4'd0) ? FREE_OUT_W'(large_cnt) : FREE_OUT_W'(stack_cnt[cls]);
            return rsp;
        endfunction

        function void note_request(t_req r);
            t_rsp rsp;
            rsp = predict_response(r);
            status_seen[rsp.status]++;
            awaited_rsp.push_back(rsp);
        endfunction

        function void check_response(t_rsp got);
            t_rsp want;
            if (awaited_rsp.size() == 0) begin
                $error("response with none outstanding: result_address %h", got.result_address);
                errors++;
                return;
            end
            want = awaited_rsp.pop_front();
            checked++;
            if (got.result_address !== want.result_address) begin
                $error("result_address: expected %h, got %h",
                       want.result_address, got.result_address);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.size_class !== want.size_class) begin
                $error("size_class: expected %0d, got %0d", want.size_class, got.size_class);
                errors++;
            end
            if (got.used_count !== want.used_count) begin
                $error("used_count: expected %0d, got %0d", want.used_count, got.used_count);
                errors++;
            end
            if (got.free_count !== want.free_count) begin
                $error("free_count: expected %0d, got %0d", want.free_count, got.free_count);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_req_valid = 1'b0;
    logic                  o_req_ready;
    t_req                  i_req = '0;
    logic                  o_rsp_valid;
    logic                  i_rsp_ready = 1'b0;
    t_rsp                  o_rsp;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    alloc_scoreboard sb;
    int  burst_left = 0;
    bit  req_held = 0;      // request valid left high after the last handshake
    int  stall_tick = 0;
    int  settings = 1;

    size_class_block_allocator_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Response side: check on every handshake, then pick the next ready.
    // Four moods in turn, picked by stall_tick bits 7:6: always ready, coin flip,
    // ready only when stall_tick bits 2:0 are zero, and mostly ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready) sb.check_response(o_rsp);
        stall_tick <= stall_tick + 1;
        case (stall_tick[7:6])
            2'd0: i_rsp_ready <= 1'b1;
            2'd1: i_rsp_ready <= $urandom_range(0, 1) == 1;
            2'd2: i_rsp_ready <= stall_tick[2:0] == 3'd0;
            default: i_rsp_ready <= $urandom_range(0, 3) != 0;
        endcase
    end

    function automatic t_req mk(logic [FUNC_W-1:0] f, logic [SIZE_W-1:0] s, logic [31:0] a);
        t_req r;
        r.func          = f;
        r.request_size  = s;
        r.block_address = a;
        return r;
    endfunction

    // A byte size somewhere inside the given page count at the current page size.
    function automatic logic [SIZE_W-1:0] size_for_pages(int pages);
        logic [63:0] lo;
        logic [63:0] span;
        logic [63:0] sz;
        if (sb.page_log >= SIZE_W) return SIZE_W'($urandom);
        span = 64'd1 << sb.page_log;
        lo   = 64'(pages - 1) << sb.page_log;
        sz   = lo + 64'($urandom_range(1, 32'(span)));
        if (sz > 64'h1FF_FFFF) return SIZE_W'($urandom);
        return sz[SIZE_W-1:0];
    endfunction

    function automatic logic [SIZE_W-1:0] random_size();
        int pages;
        case ($urandom_range(0, 9))
            0, 1: pages = 15 + ($urandom_range(0, 3) * 5);
            2:    pages = $urandom_range(15, 200);
            default: pages = $urandom_range(1, SMALL_LIMIT - 1);
        endcase
        return size_for_pages(pages);
    endfunction

    // Mostly allocate/free pairs on real blocks, plus stray frees and odd sizes.
    function automatic t_req random_request();
        t_req r;
        int   k;
        int   pick;
        r = mk(FUNC_ALLOC, random_size(), $urandom);
        k = $urandom_range(0, 99);
        if (k < 42 && sb.live.size() > 0) begin
            pick = $urandom_range(0, sb.live.size() - 1);
            r = sb.live[pick];
            sb.live.delete(pick);
        end else if (k < 52) begin
            r.func = FUNC_FREE;
        end else if (k < 57) begin
            r.request_size = SIZE_W'($urandom);
        end
        return r;
    endfunction

    // Sends one request, then either keeps valid up for the next one of the
    // burst or drops it for a random gap.
    task automatic issue(input t_req r);
        i_req_valid <= 1'b1;
        i_req       <= r;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        sb.note_request(r);
        if (burst_left > 0) begin
            burst_left--;
            req_held = 1;
        end else begin
            i_req_valid <= 1'b0;
            req_held = 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(0, 12);
        end
    endtask

    task automatic wait_drained();
        if (req_held) i_req_valid <= 1'b0;
        req_held = 0;
        @(posedge i_clk);
        while (sb.awaited_rsp.size() != 0) @(posedge i_clk);
    endtask

    // mask bit 0 page_log, bit 1 region_base, bit 2 region_limit
    task automatic configure(input logic [PL_W-1:0] pl, input logic [31:0] base,
                             input logic [31:0] lim, input int mask);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx[0] = CFG_PAGE_LOG;
        idx[1] = CFG_REGION_BASE;
        idx[2] = CFG_REGION_LIMIT;
        val[0] = CFG_DATA_W'(pl);
        val[1] = base;
        val[2] = lim;
        for (int k = 0; k < 3; k++) begin
            if (mask[k]) begin
                i_cfg_valid <= 1'b1;
                i_cfg_index <= idx[k];
                i_cfg_data  <= val[k];
                @(posedge i_clk);
                while (!o_cfg_ready) @(posedge i_clk);
                sb.write_register(idx[k], val[k]);
            end
        end
        i_cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        logic [31:0] base;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: 4 KiB pages, whole address space.
        issue(mk(FUNC_ALLOC, 25'd0, '0));                 // zero size -> one page
        issue(mk(FUNC_ALLOC, 25'd1, '0));
        issue(mk(FUNC_ALLOC, 25'd4096, '0));
        issue(mk(FUNC_ALLOC, 25'd4097, '0));              // two pages
        issue(mk(FUNC_ALLOC, 25'd57344, '0));             // largest small class
        issue(mk(FUNC_ALLOC, 25'd57345, '0));             // first large size
        issue(mk(FUNC_ALLOC, 25'd16777216, '0));
        issue(mk(FUNC_ALLOC, '1, '1));
        issue(mk(FUNC_FREE, 25'd1, 32'h0000_0000));
        issue(mk(FUNC_FREE, 25'd4096, 32'hFFFF_FFFF));
        issue(mk(FUNC_ALLOC, 25'd100, '0));               // LIFO: the last one freed
        issue(mk(FUNC_FREE, 25'd20480, 32'h0BAD_0000));   // never handed out: used stays 0
        // three large blocks, then pull them out middle, newest, oldest
        issue(mk(FUNC_FREE, 25'd61440, 32'hA000_0000));
        issue(mk(FUNC_FREE, 25'd81920, 32'hB000_0000));
        issue(mk(FUNC_FREE, 25'd122880, 32'hC000_0000));
        issue(mk(FUNC_ALLOC, 25'd81920, '0));
        issue(mk(FUNC_ALLOC, 25'd122880, '0));
        issue(mk(FUNC_ALLOC, 25'd61440, '0));
        issue(mk(FUNC_ALLOC, 25'd86016, '0));             // no match, fresh space
        issue(mk(FUNC_FREE, '1, 32'h5555_AAAA));
        issue(mk(FUNC_ALLOC, '1, '0));
        wait_drained();

        // Byte pages: large counts wrap at 16 bits, so 65551 pages meet 15.
        configure(5'd0, '0, '0, 1);
        issue(mk(FUNC_FREE, 25'd65551, 32'h1234_5000));
        issue(mk(FUNC_ALLOC, 25'd15, '0));
        issue(mk(FUNC_ALLOC, 25'd0, '0));
        wait_drained();
        // Largest page log: a 2 GiB guard plus a 2 GiB page fits exactly once.
        configure(5'd31, '0, 32'hFFFF_FFFF, 7);
        issue(mk(FUNC_ALLOC, 25'd1, '0));
        issue(mk(FUNC_ALLOC, 25'd1, '0));
        wait_drained();
        // Base above limit: no fresh space at all.
        configure(5'd12, 32'h8000_0000, 32'h7FFF_FFFF, 7);
        issue(mk(FUNC_ALLOC, 25'd4096, '0));
        issue(mk(FUNC_ALLOC, 25'd16777216, '0));
        wait_drained();
        // Block ending on the last address, then the address space runs out.
        configure(5'd12, 32'hFFFF_E000, 32'hFFFF_FFFF, 6);
        issue(mk(FUNC_ALLOC, 25'd4096, '0));
        issue(mk(FUNC_ALLOC, 25'd4096, '0));
        wait_drained();

        // Fill a small stack and the large list past full, then drain both.
        configure(5'd12, 32'h4000_0000, 32'hFFFF_FFFF, 7);
        for (int n = 0; n < STACK_DEPTH_DEF + 2; n++)
            issue(mk(FUNC_FREE, size_for_pages(3), $urandom));
        for (int n = 0; n < STACK_DEPTH_DEF + 2; n++)
            issue(mk(FUNC_ALLOC, size_for_pages(3), '0));
        for (int n = 0; n < LARGE_DEPTH_DEF + 2; n++)
            issue(mk(FUNC_FREE, size_for_pages(15 + n % 5), $urandom));
        for (int n = 0; n < LARGE_DEPTH_DEF + 2; n++)
            issue(mk(FUNC_ALLOC, size_for_pages($urandom_range(15, 20)), '0));
        wait_drained();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            base = $urandom & 32'hFFFF_F000;
            case (ph)
                0: configure(5'd9, 32'h1000_0000, 32'h1003_FFFF, 7);   // tiny region
                1: configure(5'd16, '0, 32'hFFFF_FFFF, 7);
                2: configure(5'd12, base, base + $urandom_range(0, 32'h00FF_FFFF), 7);
                3: configure(5'($urandom_range(9, 16)), 32'h2000_0000, 32'h2010_0000, 7);
                4: configure(5'd0, '0, 32'h00FF_FFFF, 7);
                5: configure(5'd0, '0, $urandom, 4);                   // limit only
                6: configure(5'($urandom_range(17, 31)), '0, 32'hFFFF_FFFF, 7);
                default: configure(PAGE_LOG_RST, 32'h4000_0000, 32'hFFFF_FFFF, 7);
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                issue(random_request());
                if ($urandom_range(0, 99) == 0) wait_drained();
            end
            wait_drained();
        end

        // wait out the longest search plus fresh space
        repeat (100) @(posedge i_clk);
        $display("Checked %0d responses under %0d register settings (%0d register writes).",
                 sb.checked, settings, sb.reg_writes);
        $display("Outcomes: %0d reused or freed, %0d fresh, %0d out of space, %0d dropped full.",
                 sb.status_seen[STAT_OK], sb.status_seen[STAT_FRESH],
                 sb.status_seen[STAT_NO_SPACE], sb.status_seen[STAT_FULL]);
        if (sb.errors == 0 && sb.awaited_rsp.size() == 0) begin
            $display("PASS size_class_block_allocator_core");
        end else begin
            $display("FAIL size_class_block_allocator_core");
        end
        $finish;
    end

    // Watchdog: fails the run if it has not finished by then.
    initial begin
        #10_000_000;
        $display("FAIL size_class_block_allocator_core");
        $finish;
    end

endmodule
